### rtl/spe_pkg.sv
// Shared constants, types and the arctangent table of the sine PCM encoder.
// Used by the design modules and the testbench; no dependencies of its own.
`timescale 1ns / 1ps
package spe_pkg;

  // Datapath widths
  localparam int PHASE_BITS    = 16;
  localparam int SAMPLE_BITS   = 16;
  localparam int MAX_CODE_BITS = 16;
  localparam int CODE_W        = 5;
  localparam int IDX_W         = $clog2(MAX_CODE_BITS);

  // CORDIC in Q2.30, angles in 2^-32 turn
  localparam int CORDIC_W      = 32;
  localparam int CORDIC_ITERS  = 20;
  localparam int ITER_W        = 5;
  localparam logic signed [CORDIC_W-1:0] CORDIC_X0 = 32'sd652032874;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_BITS    = 2'd2;
  localparam logic [CODE_W-1:0]    CODE_BITS_RESET  = 5'd8;

  // Sample handed from the CORDIC to the serializer
  typedef struct packed {
    logic                          valid;
    logic signed [SAMPLE_BITS-1:0] sample;
  } spe_smp_t;

  // atan(2^-i) in 2^-32 turn units
  function automatic logic signed [CORDIC_W-1:0] cordic_atan(input logic [ITER_W-1:0] i);
    logic signed [CORDIC_W-1:0] a;
    case (i)
      5'd0:    a = 32'sd536870912;
      5'd1:    a = 32'sd316933406;
      5'd2:    a = 32'sd167458907;
      5'd3:    a = 32'sd85004756;
      5'd4:    a = 32'sd42667331;
      5'd5:    a = 32'sd21354465;
      5'd6:    a = 32'sd10680862;
      5'd7:    a = 32'sd5340245;
      5'd8:    a = 32'sd2670163;
      5'd9:    a = 32'sd1335087;
      5'd10:   a = 32'sd667544;
      5'd11:   a = 32'sd333772;
      5'd12:   a = 32'sd166886;
      5'd13:   a = 32'sd83443;
      5'd14:   a = 32'sd41721;
      5'd15:   a = 32'sd20860;
      5'd16:   a = 32'sd10430;
      5'd17:   a = 32'sd5215;
      5'd18:   a = 32'sd2607;
      5'd19:   a = 32'sd1303;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

### rtl/spe_front.sv
// Front end: tick intake, configuration registers and the phase accumulator.
// Depends on spe_pkg; feeds phases into spe_queue.
`timescale 1ns / 1ps
module spe_front
  import spe_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  tick_valid_i,
  output logic                  tick_ready_o,
  input  logic                  restart_i,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]      cfg_data_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output logic [PHASE_BITS-1:0] phase_o,
  output logic [CODE_W-1:0]     code_bits_o
);

  logic [PHASE_BITS-1:0] step_q, step_d;
  logic [PHASE_BITS-1:0] offset_q, offset_d;
  logic [CODE_W-1:0]     code_bits_q, code_bits_d;
  logic [PHASE_BITS-1:0] time_phase_q, time_phase_d;
  logic [PHASE_BITS-1:0] base;

  // Accept a tick whenever the queue has room
  assign tick_ready_o = !q_full_i;
  assign push_o       = tick_valid_i && !q_full_i;

  // Restart clears time before this sample; phase wraps naturally
  assign base         = restart_i ? '0 : time_phase_q;
  assign phase_o      = base + offset_q;
  assign time_phase_d = push_o ? base + step_q : time_phase_q;
  assign code_bits_o  = code_bits_q;

  // Decode register writes; unknown indexes drop the write
  always_comb begin
    step_d      = step_q;
    offset_d    = offset_q;
    code_bits_d = code_bits_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_PHASE_STEP:   step_d      = cfg_data_i[PHASE_BITS-1:0];
        CFG_PHASE_OFFSET: offset_d    = cfg_data_i[PHASE_BITS-1:0];
        CFG_CODE_BITS:    code_bits_d = cfg_data_i[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q       <= '0;
      offset_q     <= '0;
      code_bits_q  <= CODE_BITS_RESET;
      time_phase_q <= '0;
    end else begin
      step_q       <= step_d;
      offset_q     <= offset_d;
      code_bits_q  <= code_bits_d;
      time_phase_q <= time_phase_d;
    end
  end

endmodule

### rtl/spe_queue.sv
// Two-entry phase queue between the front end and the CORDIC back end.
// Depends on spe_pkg.
`timescale 1ns / 1ps
module spe_queue
  import spe_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [PHASE_BITS-1:0] phase_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output logic [PHASE_BITS-1:0] phase_o
);

  logic [PHASE_BITS-1:0] mem_q [2];
  logic                  wr_ptr_q, wr_ptr_d;
  logic                  rd_ptr_q, rd_ptr_d;
  logic [1:0]            count_q, count_d;

  assign full_o  = count_q[1];
  assign valid_o = (count_q != 2'd0);
  assign phase_o = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store entry payload
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= phase_i;
    end
  end

endmodule

### rtl/spe_cordic.sv
// Back end sine unit: iterative rotation CORDIC, one iteration per cycle,
// then rounding and clamping to a Q1.15 sample. Depends on spe_pkg.
`timescale 1ns / 1ps
module spe_cordic
  import spe_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  logic [PHASE_BITS-1:0] q_phase_i,
  output logic                  q_pop_o,
  output spe_smp_t              res_o,
  input  logic                  res_ready_i
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ROT  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  localparam int PHASE_PAD = 32 - PHASE_BITS;
  localparam int RND_SH    = 31 - SAMPLE_BITS;
  localparam int RND_W     = CORDIC_W + 2;
  localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) <<< (RND_SH - 1);
  localparam logic signed [RND_W-1:0] SMP_LIM  = RND_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_ITERS - 1);

  logic [1:0]                 state_q, state_d;
  logic [ITER_W-1:0]          iter_q, iter_d;
  logic signed [CORDIC_W-1:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [1:0]                 quad_q, quad_d;
  logic signed [SAMPLE_BITS-1:0] smp_q, smp_d;

  logic                       load;
  logic [31:0]                p32;
  logic signed [CORDIC_W-1:0] dx, dy, atan_i;
  logic signed [RND_W-1:0]    v, v_rnd;

  assign p32    = {q_phase_i, {PHASE_PAD{1'b0}}};
  assign load   = q_valid_i && (state_q == ST_IDLE || (state_q == ST_DONE && res_ready_i));
  assign q_pop_o = load;

  assign res_o.valid  = (state_q == ST_DONE);
  assign res_o.sample = smp_q;

  // One rotation step, floor shifts
  assign dx     = y_q >>> iter_q;
  assign dy     = x_q >>> iter_q;
  assign atan_i = cordic_atan(iter_q);

  // Quadrant fold, round half up, clamp
  always_comb begin
    case (quad_q)
      2'd0:    v = RND_W'(y_q);
      2'd1:    v = RND_W'(x_q);
      2'd2:    v = -RND_W'(y_q);
      default: v = -RND_W'(x_q);
    endcase
    v_rnd = (v + RND_HALF) >>> RND_SH;
    if (v_rnd > SMP_LIM) begin
      smp_d = SAMPLE_BITS'(SMP_LIM);
    end else if (v_rnd < -SMP_LIM) begin
      smp_d = SAMPLE_BITS'(-SMP_LIM);
    end else begin
      smp_d = SAMPLE_BITS'(v_rnd);
    end
  end

  // Sequencer and rotation datapath
  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    quad_d  = quad_q;
    unique case (state_q)
      ST_IDLE: begin
        if (load) begin
          state_d = ST_ROT;
        end
      end
      ST_ROT: begin
        if (!z_q[CORDIC_W-1]) begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - atan_i;
        end else begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + atan_i;
        end
        iter_d = iter_q + ITER_W'(1);
        if (iter_q == ITER_LAST) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (load) begin
          state_d = ST_ROT;
        end else if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    // Start a new rotation from the queued phase
    if (load) begin
      iter_d = '0;
      x_d    = CORDIC_X0;
      y_d    = '0;
      z_d    = {2'b00, p32[29:0]};
      quad_d = p32[31:30];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold datapath registers; sample is latched in the finish step
  always_ff @(posedge clk_i) begin
    iter_q <= iter_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    quad_q <= quad_d;
    if (state_q == ST_FIN) begin
      smp_q <= smp_d;
    end
  end

endmodule

### rtl/spe_serializer.sv
// Back end output stage: quantizes a sample to a level and sends it MSB first,
// one code bit per request, through a registered output. Depends on spe_pkg.
`timescale 1ns / 1ps
module spe_serializer
  import spe_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  spe_smp_t                      res_i,
  output logic                          res_ready_o,
  input  logic [CODE_W-1:0]             code_bits_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          code_bit_o,
  output logic                          last_bit_o,
  output logic [SAMPLE_BITS-1:0]        level_o,
  output logic signed [SAMPLE_BITS-1:0] sample_o
);

  localparam logic [CODE_W-1:0] CB_MAX = CODE_W'(
      (MAX_CODE_BITS < SAMPLE_BITS) ? MAX_CODE_BITS : SAMPLE_BITS);

  logic                          valid_q, valid_d;
  logic [SAMPLE_BITS-1:0]        lvl_q;
  logic signed [SAMPLE_BITS-1:0] smp_q;
  logic [IDX_W-1:0]              idx_q, idx_d;

  logic [CODE_W-1:0]      cb;
  logic [CODE_W-1:0]      shamt;
  logic [SAMPLE_BITS-1:0] offset_bin;
  logic [SAMPLE_BITS-1:0] level;
  logic                   free;
  logic                   load;

  // Clamp the code width into 1 .. CB_MAX
  always_comb begin
    if (code_bits_i == '0) begin
      cb = CODE_W'(1);
    end else if (code_bits_i > CB_MAX) begin
      cb = CB_MAX;
    end else begin
      cb = code_bits_i;
    end
  end

  // Offset binary: adding half scale flips the sign bit
  assign offset_bin = {~res_i.sample[SAMPLE_BITS-1], res_i.sample[SAMPLE_BITS-2:0]};
  assign shamt      = CODE_W'(SAMPLE_BITS) - cb;
  assign level      = offset_bin >> shamt;

  assign free        = !valid_q || (out_ready_i && idx_q == '0);
  assign load        = free && res_i.valid;
  assign res_ready_o = free;

  assign out_valid_o = valid_q;
  assign code_bit_o  = lvl_q[idx_q];
  assign last_bit_o  = (idx_q == '0);
  assign level_o     = lvl_q;
  assign sample_o    = smp_q;

  // Step down one bit per accepted request, reload after the last
  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = IDX_W'(cb - CODE_W'(1));
    end else if (valid_q && out_ready_i) begin
      if (idx_q == '0) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q - IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  // Hold the code word for the whole burst
  always_ff @(posedge clk_i) begin
    if (load) begin
      lvl_q <= level;
      smp_q <= res_i.sample;
    end
  end

endmodule

### rtl/sine_pcm_encoder_unit.sv
// Top level of the sine PCM encoder: front end, phase queue, CORDIC, serializer.
// Depends on spe_pkg, spe_front, spe_queue, spe_cordic and spe_serializer.
//
// Usage: each request on the s_axis channel is one tick and yields one sine
// sample sin(2*pi*(time + offset)/2^16), where time advances by phase_step per
// tick; tdata bit 0 (restart) clears time to zero before that tick. The sample
// is quantized to 2^code_bits levels, code_bits clamped to 1..16, and sent on
// m_axis as code_bits requests, one code bit each, most significant first;
// tlast marks the final bit. The cfg channel writes phase_step (0),
// phase_offset (1) and code_bits (2); cfg_ready_o is always high and other
// indexes are dropped. Write only while the block is idle.
// The CORDIC works on one tick at a time and takes the next phase only once
// its sample is handed on; its 20 iterations are followed by a finish step,
// and serialization of up to 16 bits overlaps the next rotation.
// A two-entry queue takes ticks while the CORDIC works, so s_axis_tready_o
// drops only when two ticks are waiting. When the receiver stalls the current
// bit holds, the finished sample waits in the CORDIC and the queue fills.
// Reset clears time and valid state; registers return to 0, 0 and 8.
`timescale 1ns / 1ps
module sine_pcm_encoder_unit
  import spe_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [7:0]           s_axis_tdata_i,   // [0] restart, [7:1] zero
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  output logic [39:0]          m_axis_tdata_o,   // [0] code_bit, [16:1] level,
                                                 // [32:17] sample, [39:33] zero
  output logic                 m_axis_tlast_o,   // last_bit
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  logic                          q_full;
  logic                          push;
  logic [PHASE_BITS-1:0]         push_phase;
  logic [CODE_W-1:0]             code_bits;
  logic                          q_valid;
  logic                          q_pop;
  logic [PHASE_BITS-1:0]         q_phase;
  spe_smp_t                      res;
  logic                          res_ready;
  logic                          code_bit;
  logic [SAMPLE_BITS-1:0]        level;
  logic signed [SAMPLE_BITS-1:0] sample;

  assign cfg_ready_o = 1'b1;

  spe_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_valid_i (s_axis_tvalid_i),
    .tick_ready_o (s_axis_tready_o),
    .restart_i    (s_axis_tdata_i[0]),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .phase_o      (push_phase),
    .code_bits_o  (code_bits)
  );

  spe_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .phase_i (push_phase),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .phase_o (q_phase)
  );

  spe_cordic u_cordic (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_phase_i   (q_phase),
    .q_pop_o     (q_pop),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  spe_serializer u_serializer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .res_ready_o (res_ready),
    .code_bits_i (code_bits),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .code_bit_o  (code_bit),
    .last_bit_o  (m_axis_tlast_o),
    .level_o     (level),
    .sample_o    (sample)
  );

  // Pack result fields, lowest first
  assign m_axis_tdata_o = {7'b0, sample, level, code_bit};

endmodule

### rtl/spe_checker.sv
// Port-level checker for sine_pcm_encoder_unit, attached by bind.
// Depends on the top level's port list only.
`timescale 1ns / 1ps
module spe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid_i,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_i,
  input logic        m_axis_tlast_i
);

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=>
      m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tlast_i))
    else $error("output changed while stalled");

  // A code word continues without gaps and keeps its level and sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && m_axis_tready_i && !m_axis_tlast_i |=>
      m_axis_tvalid_i && $stable(m_axis_tdata_i[32:1]))
    else $error("code word broken mid-burst");

  // The final bit sent is the level's least significant bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && m_axis_tlast_i |-> m_axis_tdata_i[0] == m_axis_tdata_i[1])
    else $error("last code bit differs from level LSB");

  // Samples are clamped short of full negative scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> m_axis_tdata_i[32:17] != 16'h8000)
    else $error("sample outside clamp range");

endmodule

bind sine_pcm_encoder_unit spe_checker u_spe_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tlast_i  (m_axis_tlast_o)
);

### tb/tb_sine_pcm_encoder_unit.sv
// Testbench for sine_pcm_encoder_unit: ticks in, serial PCM code bits out.
// Predicts every code bit with its own CORDIC sine and quantizer; needs only
// the RTL and spe_pkg.
`timescale 1ns / 1ps
module tb_sine_pcm_encoder_unit;
  import spe_pkg::*;

  // Index that selects no register; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  // Gain-compensated CORDIC start value in Q2.30
  localparam longint X_START = 64'sd652032874;
  // atan(2^-i) in 2^-32 turn
  localparam longint ATAN_TURN [0:19] = '{
    536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10680862, 5340245, 2670163, 1335087,
    667544, 333772, 166886, 83443, 41721,
    20860, 10430, 5215, 2607, 1303
  };
  localparam int HOLD_CYCLES = 400;

  // One expected code bit
  typedef struct packed {
    logic                code_bit;
    logic                last_bit;
    logic [15:0]         level;
    logic signed [15:0]  sample;
  } pcm_bit_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;   // [0] restart, [7:1] zero
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [39:0]          m_tdata;        // [0] code_bit, [16:1] level, [32:17] sample
  logic                 m_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // Stimulus and scoreboard state
  logic     tick_queue [$];
  pcm_bit_t bits_due [$];
  int       mismatches = 0;
  bit       steady = 1'b0;
  int       hold_requests = 0;
  int       holds_done = 0;
  int       hold_cnt = 0;

  // Predictor copy of the registers and the time accumulator
  logic [15:0] step_reg;
  logic [15:0] offset_reg;
  logic [4:0]  code_reg;
  logic [15:0] time_acc;

  sine_pcm_encoder_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Sine of a 16-bit turn fraction, rounded to Q1.15
  function automatic logic signed [15:0] sine_q15(input logic [15:0] phase);
    logic [31:0] p32;
    longint      x, y, z, dx, dy, v;
    int          i;
    p32 = {phase, 16'h0000};
    x = X_START;
    y = 0;
    z = longint'(p32[29:0]);
    for (i = 0; i < 20; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TURN[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TURN[i];
      end
    end
    case (p32[31:30])
      2'd0:    v = y;
      2'd1:    v = x;
      2'd2:    v = -y;
      default: v = -x;
    endcase
    v = (v + 64'sd16384) >>> 15;
    if (v > 32767) v = 32767;
    if (v < -32767) v = -32767;
    return v[15:0];
  endfunction

  // Advance time for one tick and queue its code bits, MSB first
  function automatic void encode_tick(input logic restart);
    logic signed [15:0] smp;
    logic [15:0]        lvl;
    int                 width, k;
    pcm_bit_t           b;
    if (restart) time_acc = '0;
    smp = sine_q15(time_acc + offset_reg);
    time_acc = time_acc + step_reg;
    width = (code_reg == 0) ? 1 : (code_reg > 16) ? 16 : int'(code_reg);
    lvl = 16'(int'(smp) + 32768) >> (16 - width);
    for (k = 0; k < width; k++) begin
      b.code_bit = lvl[width - 1 - k];
      b.last_bit = (k == width - 1);
      b.level    = lvl;
      b.sample   = smp;
      bits_due.push_back(b);
    end
  endfunction

  // Drive ticks from the queue, predict each accepted request, track register writes
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid   <= 1'b0;
      s_tdata    <= '0;
      step_reg   = '0;
      offset_reg = '0;
      code_reg   = CODE_BITS_RESET;
      time_acc   = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PHASE_STEP:   step_reg = cfg_data;
          CFG_PHASE_OFFSET: offset_reg = cfg_data;
          CFG_CODE_BITS:    code_reg = cfg_data[4:0];
          default:          ;
        endcase
      end
      if (s_tvalid && s_tready) encode_tick(s_tdata[0]);
      if (!s_tvalid || s_tready) begin
        if (tick_queue.size() != 0 && (steady || $urandom_range(99) >= 7)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= {7'b0, tick_queue.pop_front()};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Check each accepted code bit; drive ready with random stalls and hold-offs
  always @(posedge clk_i or negedge rst_ni) begin
    pcm_bit_t exp_bit;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (bits_due.size() == 0) begin
          $error("unexpected code bit: tdata %h tlast %0d", m_tdata, m_tlast);
          mismatches++;
        end else begin
          exp_bit = bits_due.pop_front();
          if (m_tdata[0] !== exp_bit.code_bit) begin
            $error("code_bit: expected %0d, got %0d", exp_bit.code_bit, m_tdata[0]);
            mismatches++;
          end
          if (m_tlast !== exp_bit.last_bit) begin
            $error("last_bit: expected %0d, got %0d", exp_bit.last_bit, m_tlast);
            mismatches++;
          end
          if (m_tdata[16:1] !== exp_bit.level) begin
            $error("level: expected %0d, got %0d", exp_bit.level, m_tdata[16:1]);
            mismatches++;
          end
          if (m_tdata[32:17] !== exp_bit.sample) begin
            $error("sample: expected %0d, got %0d", exp_bit.sample,
                   $signed(m_tdata[32:17]));
            mismatches++;
          end
        end
      end
      if (holds_done < hold_requests) begin
        hold_cnt = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(99) >= 7);
      end
    end
  end

  // Write one register; call at a rising edge, returns once the write is taken and cfg_valid is dropped
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait until every tick is accepted and every code bit has come back
  task automatic drain();
    while (tick_queue.size() != 0 || s_tvalid || bits_due.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] corners [8];
    logic [15:0] widths [5];
    int          sent, phase_no, n, k;
    logic [15:0] cw;
    corners = '{16'h0000, 16'h3FFF, 16'h4000, 16'h4001,
                16'h8000, 16'hBFFF, 16'hC000, 16'hFFFF};
    // zero, one, just past the top, far past the top, upper bits set
    widths  = '{16'd0, 16'd1, 16'd17, 16'd31, 16'hFFE5};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: step 0, offset 0, 8-bit codes
    tick_queue.push_back(1'b0);
    tick_queue.push_back(1'b1);
    tick_queue.push_back(1'b0);
    drain();

    // Quadrant edges and phase extremes with full 16-bit codes
    write_reg(CFG_PHASE_STEP, 16'h0000);
    write_reg(CFG_CODE_BITS, 16'd16);
    foreach (corners[i]) begin
      write_reg(CFG_PHASE_OFFSET, corners[i]);
      tick_queue.push_back(1'b0);
      drain();
    end

    // Code width extremes, saturation and truncation of the written value
    foreach (widths[i]) begin
      write_reg(CFG_CODE_BITS, widths[i]);
      tick_queue.push_back(1'b1);
      drain();
    end

    // Write to an unused index: nothing changes
    write_reg(CFG_UNUSED, 16'h0003);
    tick_queue.push_back(1'b0);
    drain();

    // Phase wrap with the largest step and offset, restarts in between
    write_reg(CFG_CODE_BITS, 16'd16);
    write_reg(CFG_PHASE_STEP, 16'hFFFF);
    write_reg(CFG_PHASE_OFFSET, 16'hFFFF);
    tick_queue.push_back(1'b1);
    tick_queue.push_back(1'b0);
    tick_queue.push_back(1'b0);
    tick_queue.push_back(1'b1);
    tick_queue.push_back(1'b0);
    drain();
    write_reg(CFG_PHASE_STEP, 16'h8000);
    tick_queue.push_back(1'b0);
    tick_queue.push_back(1'b0);
    tick_queue.push_back(1'b0);
    drain();

    // Random phases: fresh settings, then a burst of ticks
    sent = 0;
    phase_no = 0;
    while (sent < 190) begin
      case ($urandom_range(3))
        0:       write_reg(CFG_PHASE_STEP, 16'($urandom_range(0, 64)));
        default: write_reg(CFG_PHASE_STEP, 16'($urandom));
      endcase
      write_reg(CFG_PHASE_OFFSET, 16'($urandom));
      case ($urandom_range(7))
        0:       cw = 16'($urandom);
        1:       cw = 16'($urandom_range(0, 31));
        2:       cw = 16'd16;
        default: cw = 16'($urandom_range(1, 16));
      endcase
      if (phase_no == 3) cw = 16'd16;
      write_reg(CFG_CODE_BITS, cw);
      steady = (phase_no == 1);
      // Long receiver hold-off while ticks keep coming
      if (phase_no == 3) hold_requests++;
      n = (phase_no == 3) ? 30 : $urandom_range(8, 30);
      for (k = 0; k < n; k++)
        tick_queue.push_back($urandom_range(9) == 0);
      sent += n;
      phase_no++;
      drain();
      steady = 1'b0;
    end

    repeat (50) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_sine_pcm_encoder_unit passed");
    end else begin
      $display("tb_sine_pcm_encoder_unit failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("tb_sine_pcm_encoder_unit failed");
    $finish;
  end

endmodule
